[design/lrupr_pkg.sv]
package lrupr_pkg;

    localparam int PAGE_W          = 20;
    localparam int CFG_W           = 4;
    localparam int OCC_OUT_W       = 4;
    localparam int TOTAL_W         = 32;
    localparam int DEF_MAX_FRAMES  = 8;

    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 56;
    localparam int M_TUSER_W       = 2;

    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [PADDR_W-1:0] ADDR_FRAMES_IN_USE = 3'd0;
    localparam logic [CFG_W-1:0]   FRAMES_RESET       = 4'd8;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX          = '1;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

[design/lru_page_replacement.sv]
// Channel   Dir  Handshake                          Word
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: page
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tuser: hit, replaced;
//                                                   tdata: evicted_page,
//                                                   frames_occupied, replacement_total
// apb       in   psel / penable / pready            reg 0 frames_in_use at 0x0
//
// One reference per cycle when not stalled; the result word appears the next cycle.
// All cells compare the page in parallel and shift in the same cycle; the
// hit position ripples up the cell row as a prefix OR.
// The output register accepts a new word in the cycle its current word is taken.
// Synchronous active-low reset empties the stack and clears the counter.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [lrupr_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,   // [19:0] page
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [lrupr_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,   // [19:0] evicted_page,
                                                                   // [23:20] frames_occupied,
                                                                   // [55:24] replacement_total
    output logic [lrupr_pkg::M_TUSER_W-1:0]     o_m_axis_tuser,   // [0] hit, [1] replaced
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrupr_pkg::PADDR_W-1:0]       paddr,
    input  logic [lrupr_pkg::PDATA_W-1:0]       pwdata,
    output logic [lrupr_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int PW    = lrupr_pkg::PAGE_W;

    logic [lrupr_pkg::CFG_W-1:0]   r_frames;
    logic [OCC_W-1:0]              r_occ;
    logic [OCC_W-1:0]              n_occ;
    logic [lrupr_pkg::TOTAL_W-1:0] r_total;
    logic [lrupr_pkg::TOTAL_W-1:0] n_total;

    logic                          r_out_valid;
    logic                          r_hit;
    logic                          r_repl;
    logic [PW-1:0]                 r_evict;
    logic [OCC_W-1:0]              r_occ_out;
    logic [lrupr_pkg::TOTAL_W-1:0] r_total_out;

    logic [OCC_W-1:0]              w_limit;
    logic [OCC_W-1:0]              w_tgt;
    logic [PW-1:0]                 w_in_page;
    logic                          w_accept;
    logic                          w_hit;
    logic                          w_append;
    logic                          w_repl;

    logic [PW-1:0]                 w_page  [MAX_FRAMES+1];
    logic                          w_seen  [MAX_FRAMES+1];
    lrupr_pkg::t_cell_ctl          w_ctl   [MAX_FRAMES];

    assign pready = 1'b1;
    assign prdata = (paddr == lrupr_pkg::ADDR_FRAMES_IN_USE)
                  ? lrupr_pkg::PDATA_W'(r_frames) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= lrupr_pkg::FRAMES_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == lrupr_pkg::ADDR_FRAMES_IN_USE) begin
            r_frames <= pwdata[lrupr_pkg::CFG_W-1:0];
        end
    end

    // frame limit: zero acts as one, above MAX_FRAMES clamps
    always_comb begin
        if (r_frames == '0) begin
            w_limit = OCC_W'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_limit = OCC_W'(MAX_FRAMES);
        end else begin
            w_limit = OCC_W'(r_frames);
        end
    end

    assign w_in_page       = i_s_axis_tdata[PW-1:0];
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_hit    = w_seen[MAX_FRAMES];
    assign w_append = !w_hit && (r_occ < w_limit);
    assign w_repl   = !w_hit && !w_append;
    assign w_tgt    = w_append ? r_occ : r_occ - OCC_W'(1);

    assign w_seen[0]          = 1'b0;
    assign w_page[MAX_FRAMES] = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        always_comb begin
            w_ctl[g].load  = w_accept && (w_tgt == OCC_W'(g));
            w_ctl[g].shift = w_accept && (32'(r_occ) > g + 1)
                           && (w_hit ? w_seen[g+1] : w_repl);
        end

        lrupr_cell u_cell (
            .i_clk   (i_clk),
            .i_page  (w_in_page),
            .i_upper (w_page[g+1]),
            .i_valid (32'(r_occ) > g),
            .i_seen  (w_seen[g]),
            .i_ctl   (w_ctl[g]),
            .o_page  (w_page[g]),
            .o_seen  (w_seen[g+1])
        );
    end

    always_comb begin
        n_occ   = w_append ? r_occ + OCC_W'(1) : r_occ;
        n_total = r_total;
        if (w_repl && r_total != lrupr_pkg::TOTAL_MAX) begin
            n_total = r_total + lrupr_pkg::TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ       <= n_occ;
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit       <= w_hit;
            r_repl      <= w_repl;
            r_evict     <= w_repl ? w_page[0] : '0;
            r_occ_out   <= n_occ;
            r_total_out <= n_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_repl, r_hit};
    assign o_m_axis_tdata  = {r_total_out,
                              lrupr_pkg::OCC_OUT_W'(32'(r_occ_out)),
                              r_evict};

endmodule

[design/lrupr_cell.sv]
module lrupr_cell (
    input  logic                            i_clk,
    input  logic [lrupr_pkg::PAGE_W-1:0]    i_page,
    input  logic [lrupr_pkg::PAGE_W-1:0]    i_upper,
    input  logic                            i_valid,
    input  logic                            i_seen,
    input  lrupr_pkg::t_cell_ctl            i_ctl,
    output logic [lrupr_pkg::PAGE_W-1:0]    o_page,
    output logic                            o_seen
);

    logic [lrupr_pkg::PAGE_W-1:0] r_page;
    logic [lrupr_pkg::PAGE_W-1:0] n_page;
    logic                         w_match;

    assign w_match = i_valid && (r_page == i_page);
    assign o_seen  = i_seen || w_match;
    assign o_page  = r_page;

    always_comb begin
        n_page = r_page;
        if (i_ctl.load) begin
            n_page = i_page;
        end else if (i_ctl.shift) begin
            n_page = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

[design/lrupr_checker.sv]
module lrupr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                o_s_axis_tready,
    input  logic [lrupr_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [lrupr_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic [lrupr_pkg::M_TUSER_W-1:0]     o_m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrupr_pkg::PADDR_W-1:0]       paddr,
    input  logic [lrupr_pkg::PDATA_W-1:0]       pwdata,
    input  logic [lrupr_pkg::PDATA_W-1:0]       prdata,
    input  logic                                pready
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    a_hit_or_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("hit and replaced both set");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> o_m_axis_tdata[19:0] == '0)
        else $error("evicted page nonzero without replacement");

    a_repl_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata[55:24] != '0)
        else $error("replacement without nonzero total");

    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:20] != '0 || o_m_axis_tuser == '0)
        else $error("empty stack reported with hit or replacement");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lrupr_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic                            hit;
        logic                            replaced;
        logic [lrupr_pkg::PAGE_W-1:0]    evicted;
        logic [lrupr_pkg::OCC_OUT_W-1:0] occupied;
        logic [lrupr_pkg::TOTAL_W-1:0]   total;
    } t_ref_outcome;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_valid = 1'b0;
    logic [lrupr_pkg::S_TDATA_W-1:0] s_data = '0;
    logic                            m_ready = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [lrupr_pkg::PADDR_W-1:0]   paddr = '0;
    logic [lrupr_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [lrupr_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;
    logic                            s_ready;
    logic                            m_valid;
    logic [lrupr_pkg::M_TDATA_W-1:0] m_data;
    logic [lrupr_pkg::M_TUSER_W-1:0] m_user;

    lru_page_replacement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // LRU shadow state
    logic [lrupr_pkg::PAGE_W-1:0]  lru_stack [lrupr_pkg::DEF_MAX_FRAMES];
    int unsigned                   resident_count;
    logic [lrupr_pkg::TOTAL_W-1:0] evict_total;
    logic [lrupr_pkg::CFG_W-1:0]   frames_reg;

    t_ref_outcome pending_outcomes[$];
    logic [lrupr_pkg::PAGE_W-1:0] page_pool[$];

    int err_count;
    int pages_sent;
    int words_checked;
    int hits_seen;
    int evictions_seen;
    int input_stalls;
    int settings_used;
    int burst_left;
    bit hold_req;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("tb: timeout at %0t", $time);
        $display("tb: failure");
        $finish;
    end

    function automatic t_ref_outcome lru_lookup(logic [lrupr_pkg::PAGE_W-1:0] pg);
        t_ref_outcome r;
        int unsigned limit;
        int unsigned occ;
        int unsigned pos;
        int unsigned j;
        r = '0;
        limit = (frames_reg == 0) ? 1 :
                (frames_reg > lrupr_pkg::DEF_MAX_FRAMES) ? lrupr_pkg::DEF_MAX_FRAMES
                                                         : frames_reg;
        occ = (resident_count > lrupr_pkg::DEF_MAX_FRAMES) ? lrupr_pkg::DEF_MAX_FRAMES
                                                           : resident_count;
        pos = 0;
        for (j = 0; j < occ; j++) begin
            if (!r.hit && lru_stack[j] == pg) begin
                r.hit = 1'b1;
                pos = j;
            end
        end
        if (r.hit) begin
            for (j = pos; j + 1 < occ; j++) lru_stack[j] = lru_stack[j+1];
            lru_stack[occ-1] = pg;
        end else if (occ < limit) begin
            lru_stack[occ] = pg;
            occ++;
        end else begin
            r.evicted = lru_stack[0];
            for (j = 0; j + 1 < occ; j++) lru_stack[j] = lru_stack[j+1];
            lru_stack[occ-1] = pg;
            r.replaced = 1'b1;
            if (evict_total != lrupr_pkg::TOTAL_MAX) evict_total++;
        end
        resident_count = occ;
        r.occupied = occ[lrupr_pkg::OCC_OUT_W-1:0];
        r.total = evict_total;
        return r;
    endfunction

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int mode;
        int run_left;
        run_left = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 60);
                end
                run_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_ref_outcome exp_r;
        if (i_rst_n && s_valid && !s_ready) input_stalls++;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tuser 0x%0h tdata 0x%0h",
                         $time, m_user, m_data);
                err_count++;
            end else begin
                exp_r = pending_outcomes.pop_front();
                check_field("hit", exp_r.hit, m_user[0]);
                check_field("replaced", exp_r.replaced, m_user[1]);
                check_field("evicted_page", exp_r.evicted, m_data[19:0]);
                check_field("frames_occupied", exp_r.occupied, m_data[23:20]);
                check_field("replacement_total", exp_r.total, m_data[55:24]);
                words_checked++;
                if (exp_r.hit) hits_seen++;
                if (exp_r.replaced) evictions_seen++;
            end
        end
    end

    task automatic send_page(input logic [lrupr_pkg::PAGE_W-1:0] pg);
        s_valid <= 1'b1;
        s_data <= {{(lrupr_pkg::S_TDATA_W-lrupr_pkg::PAGE_W){1'b0}}, pg};
        do @(posedge i_clk); while (!s_ready);
        pending_outcomes.push_back(lru_lookup(pg));
        pages_sent++;
    endtask

    task automatic send_paced(input logic [lrupr_pkg::PAGE_W-1:0] pg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        send_page(pg);
        burst_left--;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [lrupr_pkg::PADDR_W-1:0] addr,
                             input logic [lrupr_pkg::PDATA_W-1:0] data);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == lrupr_pkg::ADDR_FRAMES_IN_USE) frames_reg = data[lrupr_pkg::CFG_W-1:0];
    endtask

    task automatic set_frames(input int unsigned n);
        apb_write(lrupr_pkg::ADDR_FRAMES_IN_USE, n);
        settings_used++;
    endtask

    task automatic check_frames_readback();
        s_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= lrupr_pkg::ADDR_FRAMES_IN_USE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("frames_in_use readback", frames_reg, prdata[lrupr_pkg::CFG_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [lrupr_pkg::PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return page_pool[$urandom_range(0, page_pool.size() - 1)];
        if (r < 95) return lrupr_pkg::PAGE_W'($urandom_range(0, (1 << lrupr_pkg::PAGE_W) - 1));
        return (r < 97) ? '0 : '1;
    endfunction

    function automatic void refill_pool(int unsigned n);
        page_pool.delete();
        repeat (n) begin
            page_pool.push_back(
                lrupr_pkg::PAGE_W'($urandom_range(0, (1 << lrupr_pkg::PAGE_W) - 1)));
        end
    endfunction

    task automatic test_directed();
        send_page(20'h00000);
        set_frames(0);
        send_page(20'hFFFFF);
        send_page(20'hFFFFF);
        set_frames(3);
        send_page(20'h55555);
        send_page(20'hAAAAA);
        send_page(20'h00001);
        send_page(20'h55555);
        send_page(20'h00001);
        set_frames(lrupr_pkg::DEF_MAX_FRAMES);
        send_page(20'h80000);
        send_page(20'h7FFFF);
        send_page(20'h12345);
        send_page(20'h0FFFF);
        send_page(20'hF0000);
        send_page(20'h00000);
        send_page(20'hAAAAA);
        check_frames_readback();
    endtask

    // lowering the limit below occupancy leaves occupancy unchanged; a miss replaces the LRU page
    task automatic test_limit_lowered();
        set_frames(2);
        send_page(20'h12345);
        send_page(20'h33333);
        send_page(20'h44444);
    endtask

    task automatic test_limit_over_range();
        set_frames(15);
        send_page(20'h99999);
        set_frames(9);
        send_page(20'h00000);
        check_frames_readback();
    endtask

    task automatic test_unmapped_write();
        apb_write(ADDR_UNMAPPED, 32'h1);
        send_page(20'h66666);
        send_page(20'h99999);
        check_frames_readback();
    endtask

    task automatic test_random_refs();
        int unsigned limits[12] = '{1, 8, 3, 15, 5, 2, 0, 7, 4, 6, 9, 8};
        int unsigned eff;
        foreach (limits[k]) begin
            set_frames(limits[k]);
            eff = (limits[k] == 0) ? 1 :
                  (limits[k] > lrupr_pkg::DEF_MAX_FRAMES) ? lrupr_pkg::DEF_MAX_FRAMES
                                                          : limits[k];
            refill_pool(eff + $urandom_range(1, 4));
            burst_left = 0;
            repeat (95) send_paced(pick_page());
        end
    endtask

    // long output hold-off while the input keeps offering
    task automatic test_backpressure();
        drain_results();
        refill_pool(10);
        hold_req = 1'b1;
        repeat (40) send_page(pick_page());
        s_valid <= 1'b0;
    endtask

    initial begin
        foreach (lru_stack[k]) lru_stack[k] = '0;
        resident_count = 0;
        evict_total = '0;
        frames_reg = lrupr_pkg::FRAMES_RESET;
        err_count = 0;
        pages_sent = 0;
        words_checked = 0;
        hits_seen = 0;
        evictions_seen = 0;
        input_stalls = 0;
        settings_used = 0;
        burst_left = 0;
        hold_req = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_limit_lowered();
        test_limit_over_range();
        test_unmapped_write();
        test_random_refs();
        test_backpressure();

        drain_results();
        repeat (5) @(posedge i_clk);
        $display("tb: %0d page references over %0d frame settings, %0d words checked",
                 pages_sent, settings_used, words_checked);
        $display("tb: %0d hits, %0d evictions, %0d input stall cycles",
                 hits_seen, evictions_seen, input_stalls);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lru_page_replacement.sv
design/lrupr_checker.sv
tb/sv/testbench.sv
